// ===== hdl/scr_pkg.sv =====
package scr_pkg;

  // Register and result field widths
  localparam int FRAMES_W   = 5;
  localparam int SLOT_W     = 4;
  localparam int FAULT_W    = 32;
  localparam int OUT_DATA_W = 40;

  // Frame count after reset
  localparam logic [FRAMES_W-1:0] FRAMES_RST = 5'd16;

  // Cell operation codes
  localparam logic OP_SCAN  = 1'b0;
  localparam logic OP_SWEEP = 1'b1;

  // Broadcast command from the sequencer to every cell
  typedef struct packed {
    logic op;    // OP_SCAN or OP_SWEEP
    logic load;  // replace the token chain with a single token at load_idx
  } scr_cmd_t;

  // Status from the cell currently holding the token
  typedef struct packed {
    logic hit;   // scan: page matches this frame
    logic busy;  // sweep: frame valid with reference bit set
  } scr_stat_t;

endpackage

// ===== hdl/scr_cell.sv =====
module scr_cell #(
  parameter int INDEX     = 0,
  parameter int IW        = 4,
  parameter int PAGE_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  scr_pkg::scr_cmd_t    cmd,
  input  logic [IW-1:0]        load_idx,
  input  logic [PAGE_BITS-1:0] page,
  input  logic                 tok_in,
  output logic                 tok_out,
  output scr_pkg::scr_stat_t   stat
);
  import scr_pkg::*;

  logic [PAGE_BITS-1:0] page_r;
  logic                 valid_r, valid_nxt;
  logic                 ref_r, ref_nxt;
  logic                 tok_r, tok_nxt;
  logic                 match;
  logic                 victim;

  // Frame lookup and token decisions
  assign match  = valid_r && (page_r == page);
  assign victim = tok_r && (cmd.op == OP_SWEEP) && !(valid_r && ref_r);

  assign stat.hit  = tok_r && (cmd.op == OP_SCAN) && match;
  assign stat.busy = tok_r && (cmd.op == OP_SWEEP) && valid_r && ref_r;

  // token moves on after a miss in scan or, in sweep, when a set reference bit is cleared
  assign tok_out = tok_r && ((cmd.op == OP_SCAN) ? !match : (valid_r && ref_r));

  always_comb begin
    tok_nxt   = cmd.load ? (load_idx == IW'(INDEX)) : tok_in;
    valid_nxt = valid_r;
    ref_nxt   = ref_r;
    if (stat.hit) begin
      ref_nxt = 1'b1;
    end
    if (stat.busy || victim) begin
      ref_nxt = 1'b0;
    end
    if (victim) begin
      valid_nxt = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      ref_r   <= 1'b0;
      tok_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      ref_r   <= ref_nxt;
      tok_r   <= tok_nxt;
    end
  end

  // Page store, written only when this frame is replaced
  always_ff @(posedge clk) begin
    if (victim) begin
      page_r <= page;
    end
  end

endmodule

// ===== hdl/second_chance_page_replacer_core.sv =====
// Second-chance (clock) page replacer. Each request on in_* is one page
// reference; one result per request leaves on out_* with the hit flag, the
// frame now holding the page and the running fault count. The frames sit in a
// row of cells and a single token walks the row one frame per cycle: first
// from frame 0 upward looking for the page, then, on a miss, from the clock
// hand onward clearing reference bits until a victim frame is found. A new
// request is taken while a finished result still waits on out_*.
// cfg_data sets the frame count (0 acts as 1, above MAX_FRAMES acts as
// MAX_FRAMES); write it only while the block is idle.
module second_chance_page_replacer_core #(
  parameter int  MAX_FRAMES = 16,
  parameter int  PAGE_BITS  = 16,
  localparam int IN_W       = ((PAGE_BITS + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [IN_W-1:0]                   in_tdata,   // [PAGE_BITS-1:0] page_number
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [scr_pkg::OUT_DATA_W-1:0]    out_tdata,  // [3:0] frame_slot, [35:4] fault_total
  output logic                              out_tuser,  // hit
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [scr_pkg::FRAMES_W-1:0]      cfg_data
);
  import scr_pkg::*;

  localparam int IW    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int NW    = $clog2(MAX_FRAMES + 1);
  localparam int CW    = (NW > FRAMES_W) ? NW : FRAMES_W;
  localparam int RW    = OUT_DATA_W + 1;
  localparam int PAD_W = OUT_DATA_W - SLOT_W - FAULT_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_SWEEP = 2'd2;

  logic [1:0]           state_r, state_nxt;
  logic [IW-1:0]        idx_r, idx_nxt;
  logic [IW-1:0]        nm1_r, nm1_nxt;
  logic [IW-1:0]        hand_r, hand_nxt;
  logic [FAULT_W-1:0]   faults_r, faults_nxt;
  logic [PAGE_BITS-1:0] page_r, page_nxt;
  logic [FRAMES_W-1:0]  cfg_r;

  logic [RW-1:0]        out_r, out_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [RW-1:0]        pend_r, pend_nxt;
  logic                 pend_valid_r, pend_valid_nxt;

  scr_cmd_t             cmd;
  logic [IW-1:0]        load_idx;
  logic [IW-1:0]        start_hand;
  logic [CW-1:0]        cfg_w;
  logic [CW-1:0]        n_w;
  logic                 fin;
  logic [RW-1:0]        res;
  logic                 out_free;
  logic                 in_acc;

  scr_stat_t            stat [MAX_FRAMES];
  logic                 tok_link [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] hit_vec;
  logic [MAX_FRAMES-1:0] busy_vec;
  logic                 any_hit;
  logic                 any_busy;

  // Row of frame cells, token handed from each cell to the next
  for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
    logic tin;
    if (g == 0) begin : g_first
      assign tin = 1'b0;
    end else begin : g_rest
      assign tin = tok_link[g-1];
    end
    scr_cell #(
      .INDEX     (g),
      .IW        (IW),
      .PAGE_BITS (PAGE_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .load_idx (load_idx),
      .page     (page_r),
      .tok_in   (tin),
      .tok_out  (tok_link[g]),
      .stat     (stat[g])
    );
    assign hit_vec[g]  = stat[g].hit;
    assign busy_vec[g] = stat[g].busy;
  end

  // only the token holder reports, so these are one-hot ORs
  assign any_hit  = |hit_vec;
  assign any_busy = |busy_vec;

  assign in_tready = (state_r == ST_IDLE) && !pend_valid_r;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;

  // Active frame count, clamped to 1..MAX_FRAMES
  always_comb begin
    cfg_w = CW'(cfg_r);
    if (cfg_w == '0) begin
      n_w = CW'(1);
    end else if (cfg_w > CW'(MAX_FRAMES)) begin
      n_w = CW'(MAX_FRAMES);
    end else begin
      n_w = cfg_w;
    end
  end

  // hand wraps to frame 0 if the frame count shrank below it
  assign start_hand = (hand_r > nm1_r) ? '0 : hand_r;

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    nm1_nxt    = nm1_r;
    hand_nxt   = hand_r;
    faults_nxt = faults_r;
    page_nxt   = page_r;
    cmd.op     = (state_r == ST_SWEEP) ? OP_SWEEP : OP_SCAN;
    cmd.load   = 1'b0;
    load_idx   = '0;
    fin        = 1'b0;
    res        = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          page_nxt  = in_tdata[PAGE_BITS-1:0];
          nm1_nxt   = IW'(n_w - CW'(1));
          cmd.load  = 1'b1;
          idx_nxt   = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (any_hit) begin
          fin       = 1'b1;
          res       = {1'b1, {PAD_W{1'b0}}, faults_r, SLOT_W'(idx_r)};
          state_nxt = ST_IDLE;
        end else if (idx_r == nm1_r) begin
          // miss: restart the token at the clock hand
          cmd.load  = 1'b1;
          load_idx  = start_hand;
          idx_nxt   = start_hand;
          state_nxt = ST_SWEEP;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end
      ST_SWEEP: begin
        if (any_busy) begin
          if (idx_r == nm1_r) begin
            cmd.load = 1'b1;
            idx_nxt  = '0;
          end else begin
            idx_nxt = idx_r + IW'(1);
          end
        end else begin
          // victim found; the cell loads the page this cycle
          fin        = 1'b1;
          faults_nxt = faults_r + FAULT_W'(1);
          hand_nxt   = (idx_r == nm1_r) ? '0 : idx_r + IW'(1);
          res        = {1'b0, {PAD_W{1'b0}}, faults_nxt, SLOT_W'(idx_r)};
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register with one pending slot behind it
  always_comb begin
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    pend_nxt       = pend_r;
    pend_valid_nxt = pend_valid_r;
    if (fin) begin
      if (out_free) begin
        out_nxt       = res;
        out_valid_nxt = 1'b1;
      end else begin
        pend_nxt       = res;
        pend_valid_nxt = 1'b1;
      end
    end else if (pend_valid_r && out_free) begin
      out_nxt        = pend_r;
      out_valid_nxt  = 1'b1;
      pend_valid_nxt = 1'b0;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r[RW-1];
  assign out_tdata  = out_r[OUT_DATA_W-1:0];

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      idx_r        <= '0;
      nm1_r        <= '0;
      hand_r       <= '0;
      faults_r     <= '0;
      cfg_r        <= FRAMES_RST;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      nm1_r        <= nm1_nxt;
      hand_r       <= hand_nxt;
      faults_r     <= faults_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        cfg_r <= cfg_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    page_r <= page_nxt;
    out_r  <= out_nxt;
    pend_r <= pend_nxt;
  end

endmodule
